### rtl/windowed_trade_statistics_defines.svh
// ----------------------------------------------------------------------------
// windowed_trade_statistics_defines
// assertion macros for the windowed trade statistics block
// ----------------------------------------------------------------------------
`ifndef WINDOWED_TRADE_STATISTICS_DEFINES_SVH
`define WINDOWED_TRADE_STATISTICS_DEFINES_SVH

// implication checked on every clock edge outside reset
`define WTS_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define WTS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

### rtl/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// types and constants shared by the windowed trade statistics block
// ----------------------------------------------------------------------------
package wts_pkg;

   localparam int RING_DEPTH_DEFAULT   = 64;
   localparam int SYMBOL_CHARS_DEFAULT = 5;
   localparam int SYMBOL_WIDTH         = 8 * SYMBOL_CHARS_DEFAULT;
   localparam logic [31:0] WINDOW_RESET = 32'd60000;

   localparam logic [1:0] ACTION_RECORD   = 2'd0;
   localparam logic [1:0] ACTION_QUERY    = 2'd1;
   localparam logic [1:0] ACTION_CLEAR    = 2'd2;
   localparam logic [1:0] ACTION_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0]              action;
      logic [31:0]             trade_time;
      logic [SYMBOL_WIDTH-1:0] symbol;
      logic [31:0]             price;
      logic [31:0]             quantity;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        overflow;
      logic [31:0] window_quantity;
      logic [31:0] window_high;
      logic [31:0] window_low;
      logic [31:0] symbol_high;
      logic [31:0] symbol_low;
      logic [31:0] symbol_average;
      logic [6:0]  symbol_count;
   } rsp_type;

endpackage

### rtl/wts_divider.sv
// ----------------------------------------------------------------------------
// wts_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wts_divider
   import wts_pkg::*;
#(
   parameter int DIVIDEND_WIDTH = 38,
   parameter int DIVISOR_WIDTH  = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      done,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);
   localparam int CW = $clog2(DIVIDEND_WIDTH + 1);

   logic [DIVIDEND_WIDTH-1:0] quo_ff;
   logic [DIVISOR_WIDTH:0]    rem_ff;
   logic [DIVISOR_WIDTH-1:0]  den_ff;
   logic [CW-1:0]             cnt_ff;
   logic                      run_ff, done_ff;
   logic [DIVISOR_WIDTH:0]    trial;

   assign trial    = {rem_ff[DIVISOR_WIDTH-1:0], quo_ff[DIVIDEND_WIDTH-1]};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         quo_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= CW'(DIVIDEND_WIDTH);
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= trial - {1'b0, den_ff};
            quo_ff <= {quo_ff[DIVIDEND_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end
endmodule

### rtl/windowed_trade_statistics.sv
// ----------------------------------------------------------------------------
// windowed_trade_statistics
// ring of recent trades with window and per-symbol statistics
// ----------------------------------------------------------------------------
// usage
//   request beat: drive req_data with start high; the beat is taken when busy
//   and csr_write_enable are low, and busy stays high until the result is out
//   result beat: rsp_valid is high for exactly one cycle with rsp_data; the
//   receiver cannot stall, so the result must be captured then
//   csr_write_enable/csr_write_data update the window length; write only
//   while idle; stale entries are then dropped by a sweep of read and check
//   steps, during which busy is high
// sequence
//   a stored trade first drops stale entries by that sweep and is then
//   written; every beat then scans the live entries, one memory read then
//   one compare/accumulate step per entry, runs the divide when the symbol
//   matched and ends with the output step; a new beat is taken while the
//   result is out
// reset
//   ring empty, newest time zero, window 60000 ms; no memory clearing pass
// ----------------------------------------------------------------------------
`include "windowed_trade_statistics_defines.svh"

module windowed_trade_statistics
   import wts_pkg::*;
#(
   parameter int RING_DEPTH   = RING_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   localparam int SYMBOL_CHARS = SYMBOL_CHARS_DEFAULT;
   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int SYM_BITS = 8 * SYMBOL_CHARS;
   localparam int DVW = 32 + CW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRUNE_RD, ST_PRUNE_CHK, ST_WRITE, ST_SCAN_RD, ST_SCAN_ACC,
      ST_DIV_START, ST_DIV_WAIT, ST_OUT
   } state_type;

   // entry memory: one word per entry
   localparam int EW = 32 + SYM_BITS + 32 + 32;
   logic [EW-1:0] mem [RING_DEPTH];
   logic [EW-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   state_type      state_ff;
   logic [AW-1:0]  head_ff;
   logic [CW-1:0]  count_ff, k_ff;
   logic [31:0]    newest_ff, window_ff;
   req_type        item_ff;
   logic [SYM_BITS-1:0] sym_ff;
   logic           acc_ff, ovf_ff, after_ff;
   logic [32+CW-1:0] qsum_ff;
   logic [32+CW-1:0] psum_ff;
   logic [31:0]    whi_ff, wlo_ff, shi_ff, slo_ff, avg_ff;
   logic [CW-1:0]  scnt_ff;
   logic           div_start_ff;

   logic [31:0]    e_time, e_price, e_qty;
   logic [SYM_BITS-1:0] e_sym;
   logic           div_done;
   logic [DVW-1:0] div_quo;
   logic [SYM_BITS-1:0] sym_norm;
   logic [AW-1:0]  tail_addr;

   // zero every byte after the first zero byte
   always_comb begin
      logic ended;
      ended = 1'b0;
      sym_norm = '0;
      for (int i = SYMBOL_CHARS - 1; i >= 0; i--) begin
         if (req_data.symbol[8*i +: 8] == 8'd0) ended = 1'b1;
         if (!ended) sym_norm[8*i +: 8] = req_data.symbol[8*i +: 8];
      end
   end

   assign {e_time, e_sym, e_price, e_qty} = rd_ff;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
      logic [CW:0] s;
      s = CW'(a) + b;
      if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
      return s[AW-1:0];
   endfunction

   assign tail_addr = wrap_add(head_ff, count_ff);
   assign wr_en     = (state_ff == ST_WRITE);
   assign wr_addr   = tail_addr;

   always_comb begin
      if (state_ff == ST_SCAN_RD) rd_addr = wrap_add(head_ff, k_ff);
      else                        rd_addr = head_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= {item_ff.trade_time, sym_ff, item_ff.price, item_ff.quantity};
      rd_ff <= mem[rd_addr];
   end

   wts_divider #(.DIVIDEND_WIDTH(DVW), .DIVISOR_WIDTH(CW)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .dividend(psum_ff),
      .divisor (scnt_ff),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      div_start_ff <= 1'b0;
      rsp_valid    <= 1'b0;
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         newest_ff <= '0;
         window_ff <= WINDOW_RESET;
         after_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_write_enable) begin
                  // new window: sweep stale entries, no result
                  window_ff <= csr_write_data;
                  after_ff  <= 1'b0;
                  acc_ff    <= 1'b0;
                  item_ff.action <= ACTION_RESERVED;
                  state_ff  <= ST_PRUNE_RD;
               end else if (start) begin
                  item_ff <= req_data;
                  sym_ff  <= sym_norm;
                  acc_ff  <= 1'b0;
                  ovf_ff  <= 1'b0;
                  after_ff <= 1'b1;
                  if (req_data.action == ACTION_RECORD) begin
                     if (req_data.price != 0 && req_data.quantity != 0 &&
                         !(count_ff != 0 && req_data.trade_time < newest_ff)) begin
                        acc_ff    <= 1'b1;
                        newest_ff <= req_data.trade_time;
                        state_ff  <= ST_PRUNE_RD;
                     end else begin
                        state_ff <= ST_SCAN_RD;
                     end
                  end else if (req_data.action == ACTION_QUERY) begin
                     acc_ff   <= 1'b1;
                     state_ff <= ST_SCAN_RD;
                  end else if (req_data.action == ACTION_CLEAR) begin
                     acc_ff    <= 1'b1;
                     count_ff  <= '0;
                     head_ff   <= '0;
                     newest_ff <= '0;
                     state_ff  <= ST_SCAN_RD;
                  end else begin
                     state_ff <= ST_SCAN_RD;
                  end
                  k_ff    <= '0;
                  qsum_ff <= '0; psum_ff <= '0;
                  whi_ff <= '0; wlo_ff <= '0; shi_ff <= '0; slo_ff <= '0;
                  scnt_ff <= '0; avg_ff <= '0;
               end
            end
            ST_PRUNE_RD: begin
               if (count_ff == 0) state_ff <= after_ff ? ST_WRITE : ST_IDLE;
               else               state_ff <= ST_PRUNE_CHK;
            end
            ST_PRUNE_CHK: begin
               // drop head while time + window is below newest
               if ({1'b0, e_time} + {1'b0, window_ff} < {1'b0, newest_ff}) begin
                  head_ff  <= wrap_add(head_ff, CW'(1));
                  count_ff <= count_ff - 1'b1;
                  state_ff <= ST_PRUNE_RD;
               end else begin
                  state_ff <= after_ff ? ST_WRITE : ST_IDLE;
               end
            end
            ST_WRITE: begin
               if (count_ff >= CW'(RING_DEPTH)) begin
                  // ring full: overwrite oldest slot (tail equals head)
                  head_ff <= wrap_add(head_ff, CW'(1));
                  ovf_ff  <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
               if (k_ff >= count_ff) state_ff <= ST_DIV_START;
               else                  state_ff <= ST_SCAN_ACC;
            end
            ST_SCAN_ACC: begin
               qsum_ff <= qsum_ff + (32+CW)'(e_qty);
               if (e_price > whi_ff) whi_ff <= e_price;
               if (wlo_ff == 0 || e_price < wlo_ff) wlo_ff <= e_price;
               if (e_sym == sym_ff) begin
                  if (e_price > shi_ff) shi_ff <= e_price;
                  if (slo_ff == 0 || e_price < slo_ff) slo_ff <= e_price;
                  psum_ff <= psum_ff + (32+CW)'(e_price);
                  scnt_ff <= scnt_ff + 1'b1;
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= ST_SCAN_RD;
            end
            ST_DIV_START: begin
               if (scnt_ff != 0) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_WAIT;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  avg_ff   <= div_quo[31:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               rsp_valid                <= 1'b1;
               rsp_data.accepted        <= acc_ff;
               rsp_data.overflow        <= ovf_ff;
               rsp_data.window_quantity <= (qsum_ff[32+CW-1:32] != 0) ? 32'hFFFF_FFFF
                                                                  : qsum_ff[31:0];
               rsp_data.window_high     <= whi_ff;
               rsp_data.window_low      <= wlo_ff;
               rsp_data.symbol_high     <= shi_ff;
               rsp_data.symbol_low      <= slo_ff;
               rsp_data.symbol_average  <= avg_ff;
               rsp_data.symbol_count    <= 7'(scnt_ff);
               state_ff                 <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   `WTS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(RING_DEPTH), "count > depth")
   `WTS_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy, "result beat while busy")
   `WTS_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "beat taken, busy low")
   `WTS_ASSERT_IMPL(a_ovf_acc, clock, reset, rsp_valid && rsp_data.overflow, rsp_data.accepted, "overflow on reject")

endmodule
